// ----- src/oat_pkg.sv -----
// ----------------------------------------------------------------------------
// oat_pkg
// Shared widths, register codes and payload types for the oriented axis
// extent tracker.
// ----------------------------------------------------------------------------
package oat_pkg;

  // point coordinate and index widths
  localparam int COORD_BITS = 24;
  localparam int INDEX_BITS = 16;

  // Q1.14 unit vector components
  localparam int Q_BITS = 16;
  localparam int Q_FRAC = 14;
  localparam logic signed [Q_BITS-1:0] Q_ONE     = 16'sd16384;
  localparam logic signed [Q_BITS-1:0] Q_NEG_ONE = -16'sd16384;

  // cross product of two components, Q2.28
  localparam int CROSS_BITS = 2 * Q_BITS;

  // projection arithmetic
  localparam int DIST_BITS = 40;
  localparam int PROD_BITS = COORD_BITS + Q_BITS;
  localparam int SUM_BITS  = PROD_BITS + 2;
  localparam int WIDE_BITS = (SUM_BITS > DIST_BITS) ? SUM_BITS : DIST_BITS;

  // extremes: min and max for each of three axes
  localparam int NUM_AXES     = 3;
  localparam int NUM_EXT      = 2 * NUM_AXES;
  localparam int EXT_IDX_BITS = $clog2(NUM_EXT);

  // emitted index field
  localparam int OUT_INDEX_BITS = 16;
  localparam int IDX_WIDE_BITS  = (INDEX_BITS > OUT_INDEX_BITS) ? INDEX_BITS : OUT_INDEX_BITS;

  // configuration register port
  localparam int REG_IDX_BITS = 3;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_AXIS_X  = 3'd0,
    REG_AXIS_Y  = 3'd1,
    REG_AXIS_Z  = 3'd2,
    REG_MODEL_X = 3'd3,
    REG_MODEL_Y = 3'd4,
    REG_MODEL_Z = 3'd5
  } reg_index_t;

  // the three projection axes, x/y/z components at [0]/[1]/[2]
  typedef struct packed {
    logic [NUM_AXES-1:0][Q_BITS-1:0] model;
    logic [NUM_AXES-1:0][Q_BITS-1:0] crossed;
    logic [NUM_AXES-1:0][Q_BITS-1:0] axis;
  } axes_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic [INDEX_BITS-1:0]        point_index;
    logic                         set_end;
  } point_t;

  typedef struct packed {
    logic [1:0]                  axis_number;
    logic                        is_maximum;
    logic signed [DIST_BITS-1:0] extent_distance;
    logic [OUT_INDEX_BITS-1:0]   extreme_index;
    logic                        last_of_run;
  } result_t;

  // one point's three projections on its way to the extreme tracker
  typedef struct packed {
    logic [NUM_AXES-1:0][DIST_BITS-1:0] distance;
    logic [INDEX_BITS-1:0]              index;
    logic                               set_end;
  } proj_t;

  // the six extremes of one finished set, min/max interleaved per axis
  typedef struct packed {
    logic [NUM_EXT-1:0][DIST_BITS-1:0]  value;
    logic [NUM_EXT-1:0][INDEX_BITS-1:0] index;
  } snap_t;

endpackage

// ----- src/oat_config.sv -----
// ----------------------------------------------------------------------------
// oat_config
// Axis and model normal registers, and the registered cross-product axis.
// ----------------------------------------------------------------------------
module oat_config (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [oat_pkg::REG_IDX_BITS-1:0]    cfg_index,
  input  logic [oat_pkg::Q_BITS-1:0]          cfg_data,
  output oat_pkg::axes_t                      axes
);

  logic [oat_pkg::NUM_AXES-1:0][oat_pkg::Q_BITS-1:0] axis;
  logic [oat_pkg::NUM_AXES-1:0][oat_pkg::Q_BITS-1:0] model;
  logic [oat_pkg::NUM_AXES-1:0][oat_pkg::Q_BITS-1:0] crossed;
  logic [oat_pkg::NUM_AXES-1:0][oat_pkg::Q_BITS-1:0] crossed_next;
  logic [oat_pkg::Q_BITS-1:0]                        wr_value;

  function automatic logic [oat_pkg::Q_BITS-1:0] clamp_q(input logic [oat_pkg::Q_BITS-1:0] v);
    if ($signed(v) > oat_pkg::Q_ONE) begin
      return oat_pkg::Q_ONE;
    end else if ($signed(v) < oat_pkg::Q_NEG_ONE) begin
      return oat_pkg::Q_NEG_ONE;
    end
    return v;
  endfunction

  // round half up from Q2.28 to Q1.14, then saturate to one
  function automatic logic [oat_pkg::Q_BITS-1:0] round_q(
    input logic signed [oat_pkg::CROSS_BITS-1:0] v
  );
    logic signed [oat_pkg::CROSS_BITS-1:0] biased;
    logic signed [oat_pkg::CROSS_BITS-1:0] shifted;
    biased  = v + oat_pkg::CROSS_BITS'(1 << (oat_pkg::Q_FRAC - 1));
    shifted = biased >>> oat_pkg::Q_FRAC;
    if (shifted > oat_pkg::CROSS_BITS'(oat_pkg::Q_ONE)) begin
      return oat_pkg::Q_ONE;
    end else if (shifted < oat_pkg::CROSS_BITS'(oat_pkg::Q_NEG_ONE)) begin
      return oat_pkg::Q_NEG_ONE;
    end
    return shifted[oat_pkg::Q_BITS-1:0];
  endfunction

  function automatic logic signed [oat_pkg::CROSS_BITS-1:0] mul_q(
    input logic [oat_pkg::Q_BITS-1:0] a,
    input logic [oat_pkg::Q_BITS-1:0] b
  );
    logic signed [oat_pkg::CROSS_BITS-1:0] p;
    p = $signed(a) * $signed(b);
    return p;
  endfunction

  assign wr_value = clamp_q(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      axis  <= {oat_pkg::Q_ONE, {oat_pkg::Q_BITS{1'b0}}, {oat_pkg::Q_BITS{1'b0}}};
      model <= {{oat_pkg::Q_BITS{1'b0}}, {oat_pkg::Q_BITS{1'b0}}, oat_pkg::Q_ONE};
    end else if (cfg_write) begin
      unique case (oat_pkg::reg_index_t'(cfg_index))
        oat_pkg::REG_AXIS_X:  axis[0]  <= wr_value;
        oat_pkg::REG_AXIS_Y:  axis[1]  <= wr_value;
        oat_pkg::REG_AXIS_Z:  axis[2]  <= wr_value;
        oat_pkg::REG_MODEL_X: model[0] <= wr_value;
        oat_pkg::REG_MODEL_Y: model[1] <= wr_value;
        oat_pkg::REG_MODEL_Z: model[2] <= wr_value;
        default: ;
      endcase
    end
  end

  // axis x model
  always_comb begin
    crossed_next[0] = round_q(mul_q(axis[1], model[2]) - mul_q(axis[2], model[1]));
    crossed_next[1] = round_q(mul_q(axis[2], model[0]) - mul_q(axis[0], model[2]));
    crossed_next[2] = round_q(mul_q(axis[0], model[1]) - mul_q(axis[1], model[0]));
  end

  always_ff @(posedge clk) begin
    crossed <= crossed_next;
  end

  assign axes.model   = model;
  assign axes.crossed = crossed;
  assign axes.axis    = axis;

endmodule

// ----- src/oat_project.sv -----
// ----------------------------------------------------------------------------
// oat_project
// Three-stage projection pipeline: input register, products, saturated sums.
// ----------------------------------------------------------------------------
module oat_project (
  input  logic            clk,
  input  logic            rst,
  input  oat_pkg::axes_t  axes,
  input  logic            point_valid,
  output logic            point_stall,
  input  oat_pkg::point_t point,
  output logic            proj_valid,
  output oat_pkg::proj_t  proj,
  input  logic            take
);

  localparam logic signed [oat_pkg::WIDE_BITS-1:0] DIST_HI =
    {{(oat_pkg::WIDE_BITS - oat_pkg::DIST_BITS + 1){1'b0}}, {(oat_pkg::DIST_BITS - 1){1'b1}}};
  localparam logic signed [oat_pkg::WIDE_BITS-1:0] DIST_LO =
    {{(oat_pkg::WIDE_BITS - oat_pkg::DIST_BITS + 1){1'b1}}, {(oat_pkg::DIST_BITS - 1){1'b0}}};

  // stage 1: input register
  logic            s1_valid;
  oat_pkg::point_t s1_point;
  logic            s1_en;

  // stage 2: products
  logic                                  s2_valid;
  logic                                  s2_en;
  logic signed [oat_pkg::PROD_BITS-1:0]  s2_pm [oat_pkg::NUM_AXES];
  logic signed [oat_pkg::PROD_BITS-1:0]  s2_pc [oat_pkg::NUM_AXES];
  logic signed [oat_pkg::PROD_BITS-1:0]  s2_pa [oat_pkg::NUM_AXES];
  logic [oat_pkg::INDEX_BITS-1:0]        s2_index;
  logic                                  s2_end;

  // stage 3: sums
  logic           s3_valid;
  logic           s3_en;
  oat_pkg::proj_t s3_proj;

  logic signed [oat_pkg::COORD_BITS-1:0] coord   [oat_pkg::NUM_AXES];
  logic signed [oat_pkg::PROD_BITS-1:0]  pm_next [oat_pkg::NUM_AXES];
  logic signed [oat_pkg::PROD_BITS-1:0]  pc_next [oat_pkg::NUM_AXES];
  logic signed [oat_pkg::PROD_BITS-1:0]  pa_next [oat_pkg::NUM_AXES];
  logic [oat_pkg::NUM_AXES-1:0][oat_pkg::DIST_BITS-1:0] dist_next;

  function automatic logic [oat_pkg::DIST_BITS-1:0] sum_sat(
    input logic signed [oat_pkg::PROD_BITS-1:0] a,
    input logic signed [oat_pkg::PROD_BITS-1:0] b,
    input logic signed [oat_pkg::PROD_BITS-1:0] c
  );
    logic signed [oat_pkg::WIDE_BITS-1:0] s;
    s = oat_pkg::WIDE_BITS'(a) + oat_pkg::WIDE_BITS'(b) + oat_pkg::WIDE_BITS'(c);
    if (s > DIST_HI) begin
      s = DIST_HI;
    end else if (s < DIST_LO) begin
      s = DIST_LO;
    end
    return s[oat_pkg::DIST_BITS-1:0];
  endfunction

  // pipeline flow: a stage loads when empty or when its contents move on
  assign s3_en       = !s3_valid || take;
  assign s2_en       = !s2_valid || s3_en;
  assign s1_en       = !s1_valid || s2_en;
  assign point_stall = !s1_en;

  assign coord[0] = s1_point.point_x;
  assign coord[1] = s1_point.point_y;
  assign coord[2] = s1_point.point_z;

  always_comb begin
    for (int d = 0; d < oat_pkg::NUM_AXES; d++) begin
      pm_next[d] = coord[d] * $signed(axes.model[d]);
      pc_next[d] = coord[d] * $signed(axes.crossed[d]);
      pa_next[d] = coord[d] * $signed(axes.axis[d]);
    end
  end

  always_comb begin
    dist_next[0] = sum_sat(s2_pm[0], s2_pm[1], s2_pm[2]);
    dist_next[1] = sum_sat(s2_pc[0], s2_pc[1], s2_pc[2]);
    dist_next[2] = sum_sat(s2_pa[0], s2_pa[1], s2_pa[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid <= point_valid;
      end
      if (s2_en) begin
        s2_valid <= s1_valid;
      end
      if (s3_en) begin
        s3_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_point <= point;
    end
    if (s2_en) begin
      s2_pm    <= pm_next;
      s2_pc    <= pc_next;
      s2_pa    <= pa_next;
      s2_index <= s1_point.point_index;
      s2_end   <= s1_point.set_end;
    end
    if (s3_en) begin
      s3_proj.distance <= dist_next;
      s3_proj.index    <= s2_index;
      s3_proj.set_end  <= s2_end;
    end
  end

  assign proj_valid = s3_valid;
  assign proj       = s3_proj;

  a_proj_hold: assert property (@(posedge clk) disable iff (rst)
    s3_valid && !take |=> s3_valid && $stable(s3_proj))
    else $error("projection lost while tracker held it off");

endmodule

// ----- src/oat_extreme.sv -----
// ----------------------------------------------------------------------------
// oat_extreme
// Running min/max per axis with the index of the earliest extreme point.
// ----------------------------------------------------------------------------
module oat_extreme (
  input  logic            clk,
  input  logic            rst,
  input  logic            proj_valid,
  input  oat_pkg::proj_t  proj,
  output logic            take,
  input  logic            drain_free,
  output logic            load,
  output oat_pkg::snap_t  snap
);

  logic [oat_pkg::NUM_EXT-1:0][oat_pkg::DIST_BITS-1:0]  value;
  logic [oat_pkg::NUM_EXT-1:0][oat_pkg::INDEX_BITS-1:0] index;
  logic [oat_pkg::NUM_EXT-1:0][oat_pkg::DIST_BITS-1:0]  value_next;
  logic [oat_pkg::NUM_EXT-1:0][oat_pkg::INDEX_BITS-1:0] index_next;
  logic                                                 seen;

  // an end-marked point needs the drain free for its snapshot
  assign take = proj_valid && (!proj.set_end || drain_free);
  assign load = take && proj.set_end;

  // strict compares: a tie keeps the earlier point
  always_comb begin
    value_next = value;
    index_next = index;
    for (int d = 0; d < oat_pkg::NUM_AXES; d++) begin
      if (!seen || $signed(value[2*d]) > $signed(proj.distance[d])) begin
        value_next[2*d] = proj.distance[d];
        index_next[2*d] = proj.index;
      end
      if (!seen || $signed(value[2*d+1]) < $signed(proj.distance[d])) begin
        value_next[2*d+1] = proj.distance[d];
        index_next[2*d+1] = proj.index;
      end
    end
  end

  assign snap.value = value_next;
  assign snap.index = index_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (take) begin
      seen <= !proj.set_end;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      value <= value_next;
      index <= index_next;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> drain_free)
    else $error("snapshot loaded while previous set still draining");

endmodule

// ----- src/oat_drain.sv -----
// ----------------------------------------------------------------------------
// oat_drain
// Holds one finished set's six extremes and sends them out one per request.
// ----------------------------------------------------------------------------
module oat_drain (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  oat_pkg::snap_t   snap,
  output logic             drain_free,
  output logic             result_valid,
  input  logic             result_stall,
  output oat_pkg::result_t result
);

  localparam logic [oat_pkg::EXT_IDX_BITS-1:0] LAST_EXT =
    oat_pkg::EXT_IDX_BITS'(oat_pkg::NUM_EXT - 1);

  logic                                busy;
  logic [oat_pkg::EXT_IDX_BITS-1:0]    count;
  oat_pkg::snap_t                      held;
  logic                                advance;
  logic                                at_last;
  logic [oat_pkg::IDX_WIDE_BITS-1:0]   index_wide;

  assign at_last    = (count == LAST_EXT);
  assign advance    = busy && !result_stall;
  assign drain_free = !busy || (at_last && !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (load) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (advance) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= snap;
    end
  end

  assign index_wide = oat_pkg::IDX_WIDE_BITS'(held.index[count]);

  assign result_valid           = busy;
  assign result.axis_number     = count[oat_pkg::EXT_IDX_BITS-1:1];
  assign result.is_maximum      = count[0];
  assign result.extent_distance = held.value[count];
  assign result.extreme_index   = index_wide[oat_pkg::OUT_INDEX_BITS-1:0];
  assign result.last_of_run     = at_last;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> count <= LAST_EXT)
    else $error("drain counter past last extreme");

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    load |=> busy && count == '0)
    else $error("drain did not restart at first extreme");

endmodule

// ----- src/oriented_axis_extent_tracker.sv -----
// path: a taken point passes the input, product and sum registers to the
//   extreme tracker; an end-marked point's six results come from the drain register
// throughput: one point per cycle, set by the product and sum pipeline stages;
//   an end-marked point waits while the previous set's six results drain
// reset: synchronous, clears all valid flags, the seen flag and the drain,
//   and returns the axis and model registers to their reset values
// ----------------------------------------------------------------------------
// oriented_axis_extent_tracker
// Projects streamed points onto the model normal, the axis cross normal and
// the reference axis, tracks min/max per axis and emits six extremes per set.
// ----------------------------------------------------------------------------
module oriented_axis_extent_tracker (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_write,
  input  logic [oat_pkg::REG_IDX_BITS-1:0]  cfg_index,
  input  logic [oat_pkg::Q_BITS-1:0]        cfg_data,
  // point requests
  input  logic                              point_valid,
  output logic                              point_stall,
  input  oat_pkg::point_t                   point,
  // result requests
  output logic                              result_valid,
  input  logic                              result_stall,
  output oat_pkg::result_t                  result
);

  oat_pkg::axes_t  axes;
  logic            proj_valid;
  oat_pkg::proj_t  proj;
  logic            take;
  logic            drain_free;
  logic            load;
  oat_pkg::snap_t  snap;

  // axis registers; the cross axis is registered from them and follows in the next
  // cycle, which is well inside the idle time required around configuration writes
  oat_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .axes      (axes)
  );

  // input register, nine coordinate x component products, saturated sums
  oat_project u_project (
    .clk         (clk),
    .rst         (rst),
    .axes        (axes),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .point       (point),
    .proj_valid  (proj_valid),
    .proj        (proj),
    .take        (take)
  );

  // running extremes; on the end of a set the updated extremes go straight
  // into the drain and tracking starts fresh with the next point
  oat_extreme u_extreme (
    .clk        (clk),
    .rst        (rst),
    .proj_valid (proj_valid),
    .proj       (proj),
    .take       (take),
    .drain_free (drain_free),
    .load       (load),
    .snap       (snap)
  );

  // result stage: axis 0 min/max, axis 1 min/max, axis 2 min/max; it frees
  // up in the cycle its last result is taken, so sets can follow closely
  oat_drain u_drain (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .snap         (snap),
    .drain_free   (drain_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
